@@ rtl/rse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and GF(2^8) helpers for the Reed-Solomon encoder core.
// ----------------------------------------------------------------------------
package rse_pkg;

	// one message symbol as it arrives
	typedef struct packed {
		logic [7:0] message_symbol;
		logic       message_last;
	} msg_t;

	// one codeword symbol as it leaves
	typedef struct packed {
		logic [7:0] code_symbol;
		logic       is_parity;
		logic       codeword_last;
	} code_t;

	// register file to datapath control
	typedef struct packed {
		logic       rebuild;
		logic [7:0] poly_low;
	} ctl_t;

	// register map
	localparam logic REG_CORR = 1'b0;
	localparam logic REG_POLY = 1'b1;

	localparam logic [3:0] CORR_RESET = 4'd8;
	localparam logic [7:0] POLY_RESET = 8'h1D;

	// multiply by alpha (x) modulo x^8 + poly
	function automatic logic [7:0] gf_xtime(input logic [7:0] a, input logic [7:0] poly);
		logic [7:0] sh;
		sh = {a[6:0], 1'b0};
		return a[7] ? (sh ^ poly) : sh;
	endfunction

	// shift-and-reduce multiply, eight narrow steps
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] x;
		logic [7:0] p;
		x = a;
		p = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				p = p ^ x;
			end
			x = gf_xtime(x, poly);
		end
		return p;
	endfunction

endpackage

@@ rtl/rse_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_regs
// APB register file: correction capability and field polynomial, plus the
// derived parity length minus one, used by the datapath.
// ----------------------------------------------------------------------------
module rse_regs #(
	parameter int MAX_T = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output rse_pkg::ctl_t                  ctl,
	output logic [$clog2(2*MAX_T)-1:0]     r_m1
);
	import rse_pkg::*;

	localparam int NREG = 2 * MAX_T;
	localparam int IW   = $clog2(NREG);
	localparam int TW   = $clog2(MAX_T + 1);

	logic [3:0]  corr_q;
	logic [7:0]  poly_q;
	logic        wr_en;
	logic        idx;
	logic [TW-1:0] t_eff;
	logic [TW:0]   r_full;

	assign pready = 1'b1;
	assign idx    = paddr[2];
	assign wr_en  = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_q <= CORR_RESET;
			poly_q <= POLY_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_CORR: corr_q <= pwdata[3:0];
				REG_POLY: poly_q <= pwdata[7:0];
				default:  ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_CORR: prdata = {28'd0, corr_q};
			REG_POLY: prdata = {24'd0, poly_q};
			default:  prdata = '0;
		endcase
	end

	// clamp t into 1..MAX_T, parity length is 2t
	always_comb begin
		if (corr_q == 4'd0) begin
			t_eff = TW'(1);
		end else if (int'(corr_q) > MAX_T) begin
			t_eff = TW'(MAX_T);
		end else begin
			t_eff = TW'(corr_q);
		end
		r_full = {t_eff, 1'b0};
		r_m1   = IW'(r_full - 1'b1);
	end

	assign ctl.rebuild  = wr_en;
	assign ctl.poly_low = poly_q;

endmodule

@@ rtl/rse_genbuild.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_genbuild
// Generator polynomial builder: multiplies in one root (x + alpha^s) per
// cycle after reset or any register write.
// ----------------------------------------------------------------------------
module rse_genbuild #(
	parameter int MAX_T = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rse_pkg::ctl_t                      ctl,
	input  logic [$clog2(2*MAX_T)-1:0]         r_m1,
	output logic                               busy,
	output logic [2*MAX_T-1:0][7:0]            gen
);
	import rse_pkg::*;

	localparam int NREG = 2 * MAX_T;
	localparam int IW   = $clog2(NREG);

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [IW-1:0]         step_q;
	logic [7:0]            root_q;
	logic [7:0]            root_n;
	logic [NREG-1:0][7:0]  g_q;
	logic [NREG-1:0][7:0]  g_n;

	// next root and one polynomial multiply by (x + root)
	always_comb begin
		root_n = gf_xtime(root_q, ctl.poly_low);
		g_n[0] = gf_mul(g_q[0], root_n, ctl.poly_low);
		for (int j = 1; j < NREG; j++) begin
			g_n[j] = g_q[j-1] ^ gf_mul(g_q[j], root_n, ctl.poly_low);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			step_q  <= '0;
		end else if (ctl.rebuild) begin
			state_q <= ST_INIT;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					state_q <= ST_RUN;
					step_q  <= '0;
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == r_m1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: ;
				default: state_q <= ST_INIT;
			endcase
		end
	end

	// coefficient registers
	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			g_q    <= NREG'(1) == '0 ? '0 : {{(NREG-1){8'h00}}, 8'h01};
			root_q <= 8'h01;
		end else if (state_q == ST_RUN) begin
			g_q    <= g_n;
			root_q <= root_n;
		end
	end

	assign busy = (state_q != ST_DONE);
	assign gen  = g_q;

	// a finished build stays finished until the next register write
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && !ctl.rebuild |=> (state_q == ST_DONE))
		else $error("generator build restarted without a register write");

	// the step count never runs past the parity length
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= r_m1))
		else $error("generator build step out of range");

	// a write always restarts the build
	a_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rebuild |=> (state_q == ST_INIT))
		else $error("register write did not restart generator build");

endmodule

@@ rtl/rse_lfsr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_lfsr
// Division LFSR: one parallel remainder update per message symbol; stages at
// or above the parity length are held at zero.
// ----------------------------------------------------------------------------
module rse_lfsr #(
	parameter int MAX_T = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               step,
	input  rse_pkg::msg_t                      msg_s1,
	input  logic [7:0]                         poly_low,
	input  logic [$clog2(2*MAX_T)-1:0]         r_m1,
	input  logic [2*MAX_T-1:0][7:0]            gen,
	output logic [2*MAX_T-1:0][7:0]            rem_n
);
	import rse_pkg::*;

	localparam int NREG = 2 * MAX_T;
	localparam int IW   = $clog2(NREG);

	logic [NREG-1:0][7:0] rem_q;
	logic [7:0]           fb;

	// feedback from the top active stage
	assign fb = msg_s1.message_symbol ^ rem_q[r_m1];

	// next remainder, one multiplier per stage
	for (genvar i = 0; i < NREG; i++) begin : g_stage
		logic [7:0] prod;
		assign prod = gf_mul(fb, gen[i], poly_low);
		if (i == 0) begin : g_first
			assign rem_n[i] = prod;
		end else begin : g_rest
			assign rem_n[i] = (IW'(i) <= r_m1) ? (rem_q[i-1] ^ prod) : 8'h00;
		end
	end

	// remainder register, cleared on clear and after the last symbol of a message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (clear) begin
			rem_q <= '0;
		end else if (step) begin
			rem_q <= msg_s1.message_last ? '0 : rem_n;
		end
	end

endmodule

@@ rtl/rse_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_emit
// Output sequencer: result register plus a parity shift buffer that drains
// the 2t parity symbols, highest degree first, after the last message symbol.
// ----------------------------------------------------------------------------
module rse_emit #(
	parameter int MAX_T = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s1_valid,
	input  rse_pkg::msg_t                      msg_s1,
	input  logic [2*MAX_T-1:0][7:0]            rem_n,
	input  logic [$clog2(2*MAX_T)-1:0]         r_m1,
	output logic                               take,
	output logic                               code_valid,
	input  logic                               code_ready,
	output rse_pkg::code_t                     code
);
	import rse_pkg::*;

	localparam int NREG = 2 * MAX_T;
	localparam int IW   = $clog2(NREG);
	localparam int CW   = IW + 1;

	logic [NREG-1:0][7:0] par_q;
	logic [CW-1:0]        cnt_q;
	logic                 out_v_q;
	code_t                out_q;
	logic                 out_free;
	logic                 load_par;
	logic                 load_msg;

	// parity drain has priority over the next message symbol
	assign out_free = !out_v_q || code_ready;
	assign load_par = out_free && (cnt_q != '0);
	assign load_msg = out_free && (cnt_q == '0) && s1_valid;
	assign take     = load_msg;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load_par || load_msg) begin
				out_v_q <= 1'b1;
			end else if (code_ready) begin
				out_v_q <= 1'b0;
			end
			if (load_par) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (load_msg && msg_s1.message_last) begin
				cnt_q <= CW'(r_m1) + 1'b1;
			end
		end
	end

	// payload: result register and parity buffer
	always_ff @(posedge clk) begin
		if (load_par) begin
			out_q.code_symbol   <= par_q[r_m1];
			out_q.is_parity     <= 1'b1;
			out_q.codeword_last <= (cnt_q == CW'(1));
			for (int i = NREG - 1; i > 0; i--) begin
				par_q[i] <= par_q[i-1];
			end
			par_q[0] <= 8'h00;
		end else if (load_msg) begin
			out_q.code_symbol   <= msg_s1.message_symbol;
			out_q.is_parity     <= 1'b0;
			out_q.codeword_last <= 1'b0;
			if (msg_s1.message_last) begin
				par_q <= rem_n;
			end
		end
	end

	assign code_valid = out_v_q;
	assign code       = out_q;

	// the parity count never exceeds the parity length
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (CW'(r_m1) + 1'b1))
		else $error("parity count out of range");

	// a last message symbol arms exactly 2t parity transactions
	a_cnt_armed: assert property (@(posedge clk) disable iff (!arst_n)
		load_msg && msg_s1.message_last |=> (cnt_q == (CW'(r_m1) + 1'b1)))
		else $error("parity count not armed after last symbol");

endmodule

@@ rtl/reed_solomon_systematic_encoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reed_solomon_systematic_encoder_core
// Systematic RS encoder over GF(2^8) with configurable t and field polynomial.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   msg      | msg_valid / msg_ready      | message_symbol, message_last
//   code     | code_valid / code_ready    | code_symbol, is_parity, codeword_last
//   apb      | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One message symbol per cycle while the generator is idle, no parity drains and
// code is not stalled; a symbol reaches code via the input and result registers,
// and each codeword adds 2t parity symbols drained from the parity buffer ahead
// of the next message symbol. After reset and every register write the generator
// is rebuilt one root per cycle; msg_ready is low meanwhile.
// Output stalls back up through the result register and the input register.
// ----------------------------------------------------------------------------
module reed_solomon_systematic_encoder_core #(
	parameter int MAX_T = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_ready,
	input  rse_pkg::msg_t  msg,
	output logic           code_valid,
	input  logic           code_ready,
	output rse_pkg::code_t code,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import rse_pkg::*;

	localparam int NREG = 2 * MAX_T;
	localparam int IW   = $clog2(NREG);

	ctl_t                 ctl;
	logic [IW-1:0]        r_m1;
	logic                 busy;
	logic [NREG-1:0][7:0] gen;
	logic [NREG-1:0][7:0] rem_n;
	logic                 take;
	logic                 valid_s1;
	msg_t                 msg_s1;
	logic                 accept;

	rse_regs #(.MAX_T(MAX_T)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ctl     (ctl),
		.r_m1    (r_m1)
	);

	rse_genbuild #(.MAX_T(MAX_T)) u_genbuild (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.r_m1   (r_m1),
		.busy   (busy),
		.gen    (gen)
	);

	// input register
	assign msg_ready = !busy && (!valid_s1 || take);
	assign accept    = msg_valid && msg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			msg_s1 <= msg;
		end
	end

	rse_lfsr #(.MAX_T(MAX_T)) u_lfsr (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (busy),
		.step     (take),
		.msg_s1   (msg_s1),
		.poly_low (ctl.poly_low),
		.r_m1     (r_m1),
		.gen      (gen),
		.rem_n    (rem_n)
	);

	rse_emit #(.MAX_T(MAX_T)) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (valid_s1),
		.msg_s1     (msg_s1),
		.rem_n      (rem_n),
		.r_m1       (r_m1),
		.take       (take),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code)
	);

	// no transaction is taken while the generator is being rebuilt
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !msg_ready)
		else $error("message taken during generator build");

	// a symbol is only consumed from a full input register
	a_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> valid_s1)
		else $error("input register consumed while empty");

endmodule
